// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions of the sliding window median filter
// Holds the sample type that the channels and the sorting cells carry.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 24;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== design/swm_sample_if.sv =====
// ----------------------------------------------------------------------------
// swm_sample_if: input sample channel
// Valid/ready channel that carries one signed converter sample per transfer.
// ----------------------------------------------------------------------------
interface swm_sample_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/swm_median_if.sv =====
// ----------------------------------------------------------------------------
// swm_median_if: result channel
// Valid/ready channel that carries one window median per transfer.
// ----------------------------------------------------------------------------
interface swm_median_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

// ===== design/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_top: sliding window median filter
// Sorted row of WINDOW cells that tracks the last WINDOW samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch takes one signed 24-bit sample per transfer. median_ch gives
//   one result per sample: element WINDOW/2 of the last WINDOW samples in
//   ascending order (the upper middle value for an even window).
//   The cells keep the window sorted at all times, each tagged with its age.
//   A new sample removes the oldest entry and is inserted at its sorted
//   place in the same cycle, so one sample is taken every cycle while the receiver does not stall.
//   The median appears on median_ch in the cycle after the input
//   transfer. The input rate is set by the compare-and-shift step of the
//   cell row.
//   Reset clears the window to zeros, so the first WINDOW-1 results include
//   those zeros. No clearing pass is needed; the block is ready right after
//   reset.
//   When the receiver stalls, the result register holds its value and a new
//   sample is still taken in the cycle that the pending result is taken.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
    parameter int WINDOW = 5
) (
    input logic         clk,
    input logic         rst_n,
    swm_sample_if.sink  sample_ch,
    swm_median_if.source median_ch
);
    import swm_pkg::*;

    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID   = WINDOW / 2;

    sample_t          val      [WINDOW];
    sample_t          a_val    [WINDOW];
    sample_t          next_val [WINDOW];
    logic [AGE_W-1:0] a_age    [WINDOW];
    logic [AGE_W-1:0] age      [WINDOW];
    logic             oldest   [WINDOW];
    logic             a_gt     [WINDOW];
    logic [WINDOW-1:0] oldest_hit;
    logic [WINDOW-2:0] ordered;

    logic    load;
    logic    out_valid_reg;
    sample_t median_reg;

    assign sample_ch.ready = !out_valid_reg || median_ch.ready;
    assign load            = sample_ch.valid && sample_ch.ready;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            localparam bit IS_LAST  = (gi == WINDOW - 1);
            localparam int RIGHT_IX = IS_LAST ? gi : gi + 1;
            localparam int LEFT_IX  = (gi == 0) ? 0 : gi - 1;

            logic             oldest_left;
            sample_t          left_val;
            logic [AGE_W-1:0] left_age;
            logic             left_gt;

            if (gi == 0)
            begin : g_first
                assign oldest_left = 1'b0;
                assign left_val    = '0;
                assign left_age    = '0;
                assign left_gt     = 1'b0;
            end
            else
            begin : g_rest
                assign oldest_left = oldest[LEFT_IX];
                assign left_val    = a_val[LEFT_IX];
                assign left_age    = a_age[LEFT_IX];
                assign left_gt     = a_gt[LEFT_IX];
            end

            swm_cell #(
                .AGE_W     (AGE_W),
                .OLD_AGE   (WINDOW - 1),
                .RESET_AGE (WINDOW - 1 - gi),
                .LAST      (IS_LAST)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (load),
                .x          (sample_ch.sample),
                .right_val  (val[RIGHT_IX]),
                .right_age  (age[RIGHT_IX]),
                .oldest_in  (oldest_left),
                .left_a_val (left_val),
                .left_a_age (left_age),
                .left_gt    (left_gt),
                .val        (val[gi]),
                .age        (age[gi]),
                .oldest_out (oldest[gi]),
                .a_val      (a_val[gi]),
                .a_age      (a_age[gi]),
                .a_gt       (a_gt[gi]),
                .next_val   (next_val[gi])
            );

            assign oldest_hit[gi] = oldest[gi] && !oldest_left;

            if (gi < WINDOW - 1)
            begin : g_order
                assign ordered[gi] = (val[gi] <= val[gi+1]);
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (median_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            median_reg <= next_val[MID];
        end
    end

    assign median_ch.valid  = out_valid_reg;
    assign median_ch.median = median_reg;

    // Exactly one cell holds the oldest sample.
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(oldest_hit))
        else $error("oldest entry not unique");

    // The row stays sorted in ascending order.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &ordered)
        else $error("window row out of order");

    // Every accepted sample leaves a pending result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("accepted sample produced no result");

    // The input is held off only while a result waits on a stalled receiver.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ch.ready |-> (out_valid_reg && !median_ch.ready))
        else $error("input stalled without a pending result");

endmodule

// ===== design/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample and its age. On a load the row drops its oldest entry and
// inserts the new sample at its sorted place; each cell looks only at its
// neighbors and the new sample to find its new contents.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int AGE_W     = 3,
    parameter int OLD_AGE   = 4,
    parameter int RESET_AGE = 0,
    parameter bit LAST      = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  swm_pkg::sample_t   x,
    input  swm_pkg::sample_t   right_val,
    input  logic [AGE_W-1:0]   right_age,
    input  logic               oldest_in,
    input  swm_pkg::sample_t   left_a_val,
    input  logic [AGE_W-1:0]   left_a_age,
    input  logic               left_gt,
    output swm_pkg::sample_t   val,
    output logic [AGE_W-1:0]   age,
    output logic               oldest_out,
    output swm_pkg::sample_t   a_val,
    output logic [AGE_W-1:0]   a_age,
    output logic               a_gt,
    output swm_pkg::sample_t   next_val
);
    import swm_pkg::*;

    sample_t          val_reg;
    sample_t          val_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;

    // Once the oldest entry lies at or left of this cell, the compacted row
    // takes its element from the right neighbor.
    assign oldest_out = oldest_in | (age_reg == AGE_W'(OLD_AGE));
    assign a_val      = oldest_out ? right_val : val_reg;
    assign a_age      = oldest_out ? right_age : age_reg;
    assign a_gt       = LAST ? 1'b1 : (a_val > x);

    always_comb
    begin
        priority if (left_gt)
        begin
            val_next = left_a_val;
            age_next = left_a_age + AGE_W'(1);
        end
        else if (!a_gt)
        begin
            val_next = a_val;
            age_next = a_age + AGE_W'(1);
        end
        else
        begin
            val_next = x;
            age_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            age_reg <= AGE_W'(RESET_AGE);
        end
        else if (load)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val      = val_reg;
    assign age      = age_reg;
    assign next_val = val_next;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: sliding window median filter
// Feeds signed samples through the sample channel and checks each median
// against an in-bench predictor that keeps its own five-entry window.
// Both channels idle in random bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module testbench;
    import swm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN        = 5;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_DIRECTED = 21;
    localparam int N_BUSY     = 1700;
    localparam int N_CALM     = 280;

    logic clk = 1'b0;
    logic rst_n;

    swm_sample_if sample_ch ();
    swm_median_if median_ch ();

    sliding_window_median_top #(.WINDOW(WIN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .median_ch (median_ch)
    );

    sample_t   pending_samples[$];
    sample_t   expected_medians[$];
    sample_t   window_hist[WIN] = '{default: '0};
    int unsigned oldest_slot;
    int unsigned errors;
    int unsigned send_gap;
    int unsigned take_stall;
    int unsigned idle_cycles;
    bit        calm;
    sample_t   directed[N_DIRECTED];

    always #5 clk = ~clk;

    // Overwrites the oldest window entry and returns the upper middle value.
    function automatic sample_t insert_and_median(sample_t s);
        sample_t sorted[WIN];
        sample_t key;
        int      j;
        window_hist[oldest_slot] = s;
        oldest_slot = (oldest_slot == WIN - 1) ? 0 : oldest_slot + 1;
        sorted = window_hist;
        for (int i = 1; i < WIN; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[WIN/2];
    endfunction

    function automatic sample_t pick_sample();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2, 3, 4: return sample_t'($urandom);
            5, 6:          return sample_t'($signed($urandom_range(0, 8)) - 4);
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return sample_t'(24'h7FFFFF);
                    1:       return sample_t'(24'h800000);
                    2:       return sample_t'(0);
                    default: return sample_t'(-1);
                endcase
            end
            8:             return sample_t'(24'h7FFFF0 + $urandom_range(0, 15));
            default:       return sample_t'(24'h800000 + $urandom_range(0, 15));
        endcase
    endfunction

    task automatic report(string what, sample_t got, sample_t want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || sample_ch.valid
               || expected_medians.size() != 0)
            @(posedge clk);
    endtask

    // Driver: the predictor runs on every accepted sample transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
            send_gap         <= 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                expected_medians.push_back(insert_and_median(sample_ch.sample));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap        <= send_gap - 1;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() == 0)
                    sample_ch.valid <= 1'b0;
                else if (!calm && $urandom_range(0, 15) == 0)
                begin
                    send_gap        <= $urandom_range(0, 6);
                    sample_ch.valid <= 1'b0;
                end
                else
                begin
                    sample_ch.valid  <= 1'b1;
                    sample_ch.sample <= pending_samples.pop_front();
                end
            end
        end
    end

    // Monitor: compares each median transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_ch.ready <= 1'b0;
            take_stall      <= 0;
        end
        else
        begin
            if (median_ch.valid && median_ch.ready)
            begin
                if (expected_medians.size() == 0)
                    report("median with no sample outstanding", median_ch.median, '0);
                else
                begin
                    sample_t want;
                    want = expected_medians.pop_front();
                    if (median_ch.median !== want)
                        report("median mismatch", median_ch.median, want);
                end
            end
            if (take_stall != 0)
            begin
                take_stall      <= take_stall - 1;
                median_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                take_stall      <= $urandom_range(0, 6);
                median_ch.ready <= 1'b0;
            end
            else
                median_ch.ready <= 1'b1;
        end
    end

    // Watchdog: only cycles with work outstanding and no transfer count.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (median_ch.valid && median_ch.ready)
            || (pending_samples.size() == 0 && !sample_ch.valid
                && expected_medians.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL sliding_window_median_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        calm             = 1'b0;

        // The first results still see the cleared window, then full-scale
        // values, ties and alternating bit patterns.
        directed = '{sample_t'(24'h7FFFFF), sample_t'(24'h800000),
                     sample_t'(24'h7FFFFF), sample_t'(24'h7FFFFF),
                     sample_t'(24'h800000), sample_t'(24'h800000),
                     sample_t'(24'h800000), sample_t'(0), sample_t'(-1),
                     sample_t'(1), sample_t'(5), sample_t'(5), sample_t'(5),
                     sample_t'(-3), sample_t'(7), sample_t'(7), sample_t'(-3),
                     sample_t'(24'h7FFFFF), sample_t'(24'h800000),
                     sample_t'(24'h555555), sample_t'(24'hAAAAAA)};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            pending_samples.push_back(directed[i]);
        // The bench waits until every median so far has been taken.
        drain();

        for (int i = 0; i < N_BUSY; i++)
            pending_samples.push_back(pick_sample());
        drain();

        calm = 1'b1;
        for (int i = 0; i < N_CALM; i++)
            pending_samples.push_back(pick_sample());
        drain();

        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("PASS sliding_window_median_top");
        else
            $display("FAIL sliding_window_median_top");
        $finish;
    end
endmodule

// ===== files.f =====
design/swm_pkg.sv
design/swm_sample_if.sv
design/swm_median_if.sv
design/swm_cell.sv
design/sliding_window_median_top.sv
test/testbench.sv
